/* hdl/bmf_pkg.sv */
// Shared types and constants for the clipped box mean filter.
package bmf_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_RADIUS = 15;

    // Fixed field and register widths
    localparam int PIX_W      = 8;
    localparam int CHANNELS   = 3;
    localparam int MAX_HEIGHT = 4096;
    localparam int ROW_W      = 12;
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;
    localparam int RADREG_W   = 4;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RADIUS       = 2'd2;

    // Reset values of the registers
    localparam logic [FW_W-1:0]     RST_FRAME_WIDTH  = 11'd1024;
    localparam logic [FH_W-1:0]     RST_FRAME_HEIGHT = 13'd1024;
    localparam logic [RADREG_W-1:0] RST_RADIUS       = 4'd1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_DIV,
        ST_DONE
    } state_t;

    // Controls shared by all channel lanes
    typedef struct packed {
        logic clr;
        logic acc;
        logic rem_clr;
        logic step;
    } lane_ctl_t;

endpackage

/* hdl/bmf_ram.sv */
// Generic simple dual-port RAM with registered read.
module bmf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/bmf_lane.sv */
// One channel lane: window accumulator, restoring divider, tie-to-even rounding.
module bmf_lane
    import bmf_pkg::*;
#(
    parameter int AREA_W = 10,
    parameter int SUM_W  = 18
) (
    input  logic              clk,
    input  lane_ctl_t         ctl,
    input  logic [PIX_W-1:0]  pix,
    input  logic [AREA_W-1:0] area,
    output logic [PIX_W-1:0]  mean
);

    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [AREA_W-1:0] rem_reg, rem_next;
    logic [AREA_W:0]   part;
    logic [AREA_W:0]   trial;
    logic              ge;
    logic [AREA_W:0]   twice;
    logic              inc;

    // one quotient bit per step
    always_comb
    begin
        part  = {rem_reg, sum_reg[SUM_W-1]};
        ge    = (part >= {1'b0, area});
        trial = part - {1'b0, area};
    end

    // sum register holds the running sum, then the quotient
    always_comb
    begin
        sum_next = sum_reg;
        rem_next = rem_reg;
        if (ctl.clr)
        begin
            sum_next = '0;
        end
        else if (ctl.acc)
        begin
            sum_next = sum_reg + SUM_W'(pix);
        end
        else if (ctl.step)
        begin
            sum_next = {sum_reg[SUM_W-2:0], ge};
        end
        if (ctl.rem_clr)
        begin
            rem_next = '0;
        end
        else if (ctl.step)
        begin
            rem_next = ge ? trial[AREA_W-1:0] : part[AREA_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        rem_reg <= rem_next;
    end

    // round to nearest, ties to even
    always_comb
    begin
        twice = {rem_reg, 1'b0};
        inc   = (twice > {1'b0, area}) || ((twice == {1'b0, area}) && sum_reg[0]);
        mean  = sum_reg[PIX_W-1:0] + PIX_W'(inc);
    end

endmodule

/* hdl/box_mean_filter_clipped.sv */
// Top level of the clipped box mean filter: control, row store, lanes, output register.
//
//  channel | signals                              | payload
//  --------+--------------------------------------+---------------------------------------
//  in      | s_tvalid s_tready s_tdata s_tuser    | tdata: chan0,chan1,chan2; tuser: req_type
//  out     | m_tvalid m_tready m_tdata m_tlast    | tdata: mean0,mean1,mean2; tlast: frame_last
//  config  | psel penable pwrite paddr pwdata ... | frame_width@0, frame_height@4, radius@8
//
// A request that releases no output leaves the sequencer idle. A request that releases an
// output does one row-store read per window pixel (single read port), then SUM_W steps of
// the per-lane bit-serial divider. Input is held off while a window is computed; a finished
// result waits in the output register while the next request is taken. Reset clears the
// frame positions, sequencer and output valid, not the window payload registers; the row
// store needs no clearing since only pixels of the current frame are read.
module box_mean_filter_clipped
    import bmf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [23:0]       s_tdata,   // chan0, chan1, chan2
    input  logic              s_tuser,   // req_type
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,   // mean0, mean1, mean2
    output logic              m_tlast,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WE_W   = COL_W + 1;
    localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
    localparam int SLOTS  = 2 * MAX_RADIUS + 2;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int AREA_W = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
    localparam int SUM_W  = PIX_W + AREA_W;
    localparam int POS_W  = COL_W + ROW_W + 1;
    localparam int CNT_W  = $clog2(SUM_W + 1);
    localparam int RAM_D  = SLOTS * (2 ** COL_W);
    localparam int RAM_AW = $clog2(RAM_D);

    // configuration
    logic [FW_W-1:0]     frame_width_reg;
    logic [FH_W-1:0]     frame_height_reg;
    logic [RADREG_W-1:0] radius_reg;
    logic                cfg_wr;

    // frame positions
    logic [COL_W-1:0]  in_col_reg, in_col_next;
    logic [ROW_W-1:0]  in_row_reg, in_row_next;
    logic [SLOT_W-1:0] in_slot_reg, in_slot_next;
    logic [POS_W-1:0]  in_pos_reg, in_pos_next;
    logic              in_done_reg, in_done_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [ROW_W-1:0]  out_row_reg, out_row_next;
    logic [SLOT_W-1:0] out_slot_reg, out_slot_next;

    // window sequencing
    logic [COL_W-1:0]  x0_reg, x0_next;
    logic [COL_W-1:0]  x1_reg, x1_next;
    logic [COL_W-1:0]  cur_x_reg, cur_x_next;
    logic [SLOT_W-1:0] cur_slot_reg, cur_slot_next;
    logic [SLOT_W-1:0] rows_left_reg, rows_left_next;
    logic [AREA_W-1:0] area_reg, area_next;
    logic              last_reg, last_next;
    logic              rd_vld_reg;
    logic [CNT_W-1:0]  div_cnt_reg;

    state_t state_reg, state_next;

    // output register
    logic              m_tvalid_reg;
    logic [23:0]       m_tdata_reg;
    logic              m_tlast_reg;

    // effective configuration
    logic [WE_W-1:0]  w_eff;
    logic [FH_W-1:0]  h_eff;
    logic [RAD_W-1:0] r_eff;
    logic [POS_W-1:0] lag;

    // request decode and base positions
    logic              s_accept, is_flush, restart, do_emit, out_load, rd_en, last_issue;
    logic [COL_W-1:0]  b_in_col, b_out_col;
    logic [ROW_W-1:0]  b_in_row, b_out_row;
    logic [SLOT_W-1:0] b_in_slot, b_out_slot;
    logic [POS_W-1:0]  b_in_pos;

    // window bounds
    logic              row_ok, col_ok;
    logic [ROW_W-1:0]  y0, y1;
    logic [ROW_W:0]    ysum;
    logic [COL_W-1:0]  x0, x1;
    logic [WE_W-1:0]   xsum;
    logic [RAD_W-1:0]  dr;
    logic [SLOT_W:0]   slot_tmp;
    logic [SLOT_W-1:0] win_rows, win_cols;
    logic [2*SLOT_W-1:0] area_full;

    lane_ctl_t lane_ctl;
    logic [23:0] ram_rd_data;
    logic [PIX_W-1:0] lane_mean [CHANNELS];

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= RST_FRAME_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
            radius_reg       <= RST_RADIUS;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[FW_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[FH_W-1:0];
                REG_RADIUS:       radius_reg       <= pwdata[RADREG_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_FRAME_WIDTH:  prdata = DATA_W'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = DATA_W'(frame_height_reg);
            REG_RADIUS:       prdata = DATA_W'(radius_reg);
            default:          prdata = '0;
        endcase
    end

    // clamp configuration into range
    always_comb
    begin
        if (frame_width_reg == '0)
            w_eff = WE_W'(1);
        else if (32'(frame_width_reg) > MAX_WIDTH)
            w_eff = WE_W'(MAX_WIDTH);
        else
            w_eff = WE_W'(frame_width_reg);
        if (frame_height_reg == '0)
            h_eff = FH_W'(1);
        else if (32'(frame_height_reg) > MAX_HEIGHT)
            h_eff = FH_W'(MAX_HEIGHT);
        else
            h_eff = frame_height_reg;
        if (32'(radius_reg) > MAX_RADIUS)
            r_eff = RAD_W'(MAX_RADIUS);
        else
            r_eff = RAD_W'(radius_reg);
        lag = POS_W'(32'(r_eff) * 32'(w_eff) + 32'(r_eff));
    end

    // request decode
    assign s_accept = s_tvalid && s_tready;
    assign is_flush = s_tuser;
    assign restart  = !is_flush && in_done_reg;

    always_comb
    begin
        b_in_col   = restart ? '0 : in_col_reg;
        b_in_row   = restart ? '0 : in_row_reg;
        b_in_slot  = restart ? '0 : in_slot_reg;
        b_in_pos   = restart ? '0 : in_pos_reg;
        b_out_col  = restart ? '0 : out_col_reg;
        b_out_row  = restart ? '0 : out_row_reg;
        b_out_slot = restart ? '0 : out_slot_reg;
        do_emit    = is_flush ? in_done_reg : (b_in_pos >= lag);
    end

    // window bounds of the output pixel
    always_comb
    begin
        row_ok   = (b_out_row >= ROW_W'(r_eff));
        y0       = row_ok ? b_out_row - ROW_W'(r_eff) : '0;
        ysum     = {1'b0, b_out_row} + (ROW_W + 1)'(r_eff);
        y1       = (ysum > (ROW_W + 1)'(h_eff - 1'b1)) ? ROW_W'(h_eff - 1'b1)
                                                      : ysum[ROW_W-1:0];
        col_ok   = (b_out_col >= COL_W'(r_eff));
        x0       = col_ok ? b_out_col - COL_W'(r_eff) : '0;
        xsum     = {1'b0, b_out_col} + WE_W'(r_eff);
        x1       = (xsum > w_eff - 1'b1) ? COL_W'(w_eff - 1'b1) : xsum[COL_W-1:0];
        win_rows = SLOT_W'(y1 - y0 + 1'b1);
        win_cols = SLOT_W'(x1 - x0 + 1'b1);
        area_full = win_rows * win_cols;
        dr       = row_ok ? r_eff : b_out_row[RAD_W-1:0];
        if ({1'b0, b_out_slot} >= (SLOT_W + 1)'(dr))
            slot_tmp = {1'b0, b_out_slot} - (SLOT_W + 1)'(dr);
        else
            slot_tmp = {1'b0, b_out_slot} + (SLOT_W + 1)'(SLOTS) - (SLOT_W + 1)'(dr);
    end

    assign last_issue = (cur_x_reg == x1_reg) && (rows_left_reg == SLOT_W'(1));

    // frame position and window register updates
    always_comb
    begin
        in_col_next    = in_col_reg;
        in_row_next    = in_row_reg;
        in_slot_next   = in_slot_reg;
        in_pos_next    = in_pos_reg;
        in_done_next   = in_done_reg;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        out_slot_next  = out_slot_reg;
        x0_next        = x0_reg;
        x1_next        = x1_reg;
        cur_x_next     = cur_x_reg;
        cur_slot_next  = cur_slot_reg;
        rows_left_next = rows_left_reg;
        area_next      = area_reg;
        last_next      = last_reg;

        if (cfg_wr && (paddr[3:2] == REG_FRAME_WIDTH || paddr[3:2] == REG_FRAME_HEIGHT
                       || paddr[3:2] == REG_RADIUS))
        begin
            in_col_next   = '0;
            in_row_next   = '0;
            in_slot_next  = '0;
            in_pos_next   = '0;
            in_done_next  = 1'b0;
            out_col_next  = '0;
            out_row_next  = '0;
            out_slot_next = '0;
        end
        else if (s_accept)
        begin
            if (!is_flush)
            begin
                in_col_next  = b_in_col;
                in_row_next  = b_in_row;
                in_slot_next = b_in_slot;
                in_pos_next  = b_in_pos + 1'b1;
                in_done_next = 1'b0;
                out_col_next  = b_out_col;
                out_row_next  = b_out_row;
                out_slot_next = b_out_slot;
                if ((FH_W'(b_in_row) == h_eff - 1'b1) && (WE_W'(b_in_col) == w_eff - 1'b1))
                begin
                    in_done_next = 1'b1;
                end
                else if (WE_W'(b_in_col) == w_eff - 1'b1)
                begin
                    in_col_next  = '0;
                    in_row_next  = b_in_row + 1'b1;
                    in_slot_next = (b_in_slot == SLOT_W'(SLOTS - 1)) ? '0 : b_in_slot + 1'b1;
                end
                else
                begin
                    in_col_next = b_in_col + 1'b1;
                end
            end
            if (do_emit)
            begin
                x0_next        = x0;
                x1_next        = x1;
                cur_x_next     = x0;
                cur_slot_next  = slot_tmp[SLOT_W-1:0];
                rows_left_next = win_rows;
                area_next      = AREA_W'(area_full);
                last_next      = (FH_W'(b_out_row) == h_eff - 1'b1)
                              && (WE_W'(b_out_col) == w_eff - 1'b1);
                if (last_next)
                begin
                    in_col_next   = '0;
                    in_row_next   = '0;
                    in_slot_next  = '0;
                    in_pos_next   = '0;
                    in_done_next  = 1'b0;
                    out_col_next  = '0;
                    out_row_next  = '0;
                    out_slot_next = '0;
                end
                else if (WE_W'(b_out_col) == w_eff - 1'b1)
                begin
                    out_col_next  = '0;
                    out_row_next  = b_out_row + 1'b1;
                    out_slot_next = (b_out_slot == SLOT_W'(SLOTS - 1)) ? '0
                                                                       : b_out_slot + 1'b1;
                end
                else
                begin
                    out_col_next = b_out_col + 1'b1;
                end
            end
        end
        else if (state_reg == ST_READ)
        begin
            if (cur_x_reg == x1_reg)
            begin
                cur_x_next     = x0_reg;
                rows_left_next = rows_left_reg - 1'b1;
                cur_slot_next  = (cur_slot_reg == SLOT_W'(SLOTS - 1)) ? '0
                                                                      : cur_slot_reg + 1'b1;
            end
            else
            begin
                cur_x_next = cur_x_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            in_slot_reg   <= '0;
            in_pos_reg    <= '0;
            in_done_reg   <= 1'b0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            out_slot_reg  <= '0;
            rows_left_reg <= '0;
            state_reg     <= ST_IDLE;
            rd_vld_reg    <= 1'b0;
            div_cnt_reg   <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            in_col_reg    <= in_col_next;
            in_row_reg    <= in_row_next;
            in_slot_reg   <= in_slot_next;
            in_pos_reg    <= in_pos_next;
            in_done_reg   <= in_done_next;
            out_col_reg   <= out_col_next;
            out_row_reg   <= out_row_next;
            out_slot_reg  <= out_slot_next;
            rows_left_reg <= rows_left_next;
            state_reg     <= state_next;
            rd_vld_reg    <= rd_en;
            if (state_reg == ST_DRAIN)
                div_cnt_reg <= '0;
            else if (state_reg == ST_DIV)
                div_cnt_reg <= div_cnt_reg + 1'b1;
            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // window payload registers
    always_ff @(posedge clk)
    begin
        x0_reg       <= x0_next;
        x1_reg       <= x1_next;
        cur_x_reg    <= cur_x_next;
        cur_slot_reg <= cur_slot_next;
        area_reg     <= area_next;
        last_reg     <= last_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_accept && do_emit) state_next = ST_READ;
            ST_READ:  if (last_issue) state_next = ST_DRAIN;
            ST_DRAIN: state_next = ST_DIV;
            ST_DIV:   if (div_cnt_reg == CNT_W'(SUM_W - 1)) state_next = ST_DONE;
            ST_DONE:  if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        s_tready         = 1'b0;
        rd_en            = 1'b0;
        out_load         = 1'b0;
        lane_ctl.clr     = 1'b0;
        lane_ctl.acc     = rd_vld_reg;
        lane_ctl.rem_clr = 1'b0;
        lane_ctl.step    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready     = 1'b1;
                lane_ctl.clr = 1'b1;
            end
            ST_READ:  rd_en = 1'b1;
            ST_DRAIN: lane_ctl.rem_clr = 1'b1;
            ST_DIV:   lane_ctl.step = 1'b1;
            ST_DONE:  out_load = !m_tvalid_reg || m_tready;
            default:  ;
        endcase
    end

    // row store ring
    bmf_ram #(
        .WIDTH (24),
        .DEPTH (RAM_D)
    ) u_row_store (
        .clk     (clk),
        .wr_en   (s_accept && !is_flush),
        .wr_addr (RAM_AW'({b_in_slot, b_in_col})),
        .wr_data (s_tdata),
        .rd_en   (rd_en),
        .rd_addr (RAM_AW'({cur_slot_reg, cur_x_reg})),
        .rd_data (ram_rd_data)
    );

    // channel lanes
    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_lane
        bmf_lane #(
            .AREA_W (AREA_W),
            .SUM_W  (SUM_W)
        ) u_lane (
            .clk  (clk),
            .ctl  (lane_ctl),
            .pix  (ram_rd_data[c*PIX_W +: PIX_W]),
            .area (area_reg),
            .mean (lane_mean[c])
        );
    end

    // merge lanes into the output register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_tdata_reg <= {lane_mean[2], lane_mean[1], lane_mean[0]};
            m_tlast_reg <= last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // checks
    a_read_rows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> (rows_left_reg != '0))
        else $error("window read with no rows left");

    a_drain_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |=> (state_reg == ST_DIV && div_cnt_reg == '0))
        else $error("divider not started after drain");

    a_done_pos: assert property (@(posedge clk) disable iff (!rst_n)
        in_done_reg |-> (WE_W'(in_col_reg) == w_eff - 1'b1))
        else $error("frame read in but input column not at row end");

endmodule
